// ===== hdl/ssp_pkg.sv =====
package ssp_pkg;

	localparam int unsigned VALUE_W = 64;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned SHIFT_W = 5;

	// Parse phase, one-hot
	typedef enum logic [5:0] {
		PH_START  = 6'b000001,
		PH_SIGN   = 6'b000010,
		PH_DIGITS = 6'b000100,
		PH_UNIT   = 6'b001000,
		PH_I      = 6'b010000,
		PH_B      = 6'b100000
	} phase_t;

	typedef struct packed {
		phase_t               phase;
		logic                 failed;
		logic [SHIFT_W-1:0]   unit_shift;
		logic                 digit_seen;
		logic [VALUE_W-1:0]   acc;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase:      PH_START,
		failed:     1'b0,
		unit_shift: '0,
		digit_seen: 1'b0,
		acc:        '0
	};

	// Unit scale codes
	localparam logic [SHIFT_W-1:0] SHIFT_NONE = 5'd0;
	localparam logic [SHIFT_W-1:0] SHIFT_KILO = 5'd10;
	localparam logic [SHIFT_W-1:0] SHIFT_MEGA = 5'd20;
	localparam logic [SHIFT_W-1:0] SHIFT_GIGA = 5'd30;

	// Characters
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_CASE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_K     = 8'h6B;
	localparam logic [CHAR_W-1:0] CH_M     = 8'h6D;
	localparam logic [CHAR_W-1:0] CH_G     = 8'h67;
	localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
	localparam logic [CHAR_W-1:0] CH_B     = 8'h62;

endpackage

// ===== hdl/ssp_step.sv =====
// Next-state and result logic for one character of the size string.
module ssp_step (
	input  ssp_pkg::parse_state_t          cur,
	input  logic [ssp_pkg::CHAR_W-1:0]     character,
	output ssp_pkg::parse_state_t          nxt,
	output logic [ssp_pkg::VALUE_W-1:0]    size_bytes,
	output logic                           parse_error
);

	logic [ssp_pkg::CHAR_W-1:0]    lc;
	logic                          is_blank;
	logic                          is_digit;
	logic [3:0]                    digit;
	logic [ssp_pkg::VALUE_W+3:0]   prod;
	logic                          mul_ovf;
	logic                          scale_ovf;
	logic [ssp_pkg::VALUE_W-1:0]   scaled;
	logic                          err;

	assign lc = (character >= ssp_pkg::CH_UP_A && character <= ssp_pkg::CH_UP_Z) ?
		(character | ssp_pkg::CH_CASE) : character;
	assign is_blank = (character == ssp_pkg::CH_SPACE) ||
		(character >= ssp_pkg::CH_TAB && character <= ssp_pkg::CH_CR);
	assign is_digit = (character >= ssp_pkg::CH_ZERO) && (character <= ssp_pkg::CH_NINE);
	assign digit    = 4'(character - ssp_pkg::CH_ZERO);

	// acc * 10 + digit as shift-add, carried wide enough to see overflow
	assign prod = ({4'b0, cur.acc} << 3) + ({4'b0, cur.acc} << 1) +
		{{(ssp_pkg::VALUE_W){1'b0}}, digit};
	assign mul_ovf = |prod[ssp_pkg::VALUE_W+3:ssp_pkg::VALUE_W];

	// scaling overflows when any of the top unit_shift bits is set
	always_comb begin
		unique case (cur.unit_shift)
			ssp_pkg::SHIFT_KILO: begin
				scale_ovf = |cur.acc[63:54];
				scaled    = cur.acc << 10;
			end
			ssp_pkg::SHIFT_MEGA: begin
				scale_ovf = |cur.acc[63:44];
				scaled    = cur.acc << 20;
			end
			ssp_pkg::SHIFT_GIGA: begin
				scale_ovf = |cur.acc[63:34];
				scaled    = cur.acc << 30;
			end
			default: begin
				scale_ovf = 1'b0;
				scaled    = cur.acc;
			end
		endcase
	end

	assign err = cur.failed || !cur.digit_seen || (cur.phase == ssp_pkg::PH_START) ||
		(cur.phase == ssp_pkg::PH_SIGN) || scale_ovf;
	assign size_bytes  = err ? '0 : scaled;
	assign parse_error = err;

	always_comb begin
		nxt = cur;
		if (character == ssp_pkg::CH_NUL) begin
			nxt = ssp_pkg::STATE_RESET;
		end else if (!cur.failed) begin
			unique case (cur.phase)
				ssp_pkg::PH_START: begin
					if (is_blank) begin
						nxt.phase = ssp_pkg::PH_START;
					end else if (character == ssp_pkg::CH_PLUS) begin
						nxt.phase = ssp_pkg::PH_SIGN;
					end else if (is_digit) begin
						nxt.phase      = ssp_pkg::PH_DIGITS;
						nxt.digit_seen = 1'b1;
						nxt.failed     = mul_ovf;
						nxt.acc        = mul_ovf ? cur.acc : prod[ssp_pkg::VALUE_W-1:0];
					end else begin
						nxt.failed = 1'b1;
					end
				end
				ssp_pkg::PH_SIGN, ssp_pkg::PH_DIGITS: begin
					if (is_digit) begin
						nxt.phase      = ssp_pkg::PH_DIGITS;
						nxt.digit_seen = 1'b1;
						nxt.failed     = mul_ovf;
						nxt.acc        = mul_ovf ? cur.acc : prod[ssp_pkg::VALUE_W-1:0];
					end else if (cur.phase == ssp_pkg::PH_DIGITS && lc == ssp_pkg::CH_K) begin
						nxt.unit_shift = ssp_pkg::SHIFT_KILO;
						nxt.phase      = ssp_pkg::PH_UNIT;
					end else if (cur.phase == ssp_pkg::PH_DIGITS && lc == ssp_pkg::CH_M) begin
						nxt.unit_shift = ssp_pkg::SHIFT_MEGA;
						nxt.phase      = ssp_pkg::PH_UNIT;
					end else if (cur.phase == ssp_pkg::PH_DIGITS && lc == ssp_pkg::CH_G) begin
						nxt.unit_shift = ssp_pkg::SHIFT_GIGA;
						nxt.phase      = ssp_pkg::PH_UNIT;
					end else begin
						nxt.failed = 1'b1;
					end
				end
				ssp_pkg::PH_UNIT: begin
					if (lc == ssp_pkg::CH_I) begin
						nxt.phase = ssp_pkg::PH_I;
					end else if (lc == ssp_pkg::CH_B) begin
						nxt.phase = ssp_pkg::PH_B;
					end else begin
						nxt.failed = 1'b1;
					end
				end
				ssp_pkg::PH_I: begin
					if (lc == ssp_pkg::CH_B) begin
						nxt.phase = ssp_pkg::PH_B;
					end else begin
						nxt.failed = 1'b1;
					end
				end
				default: begin
					nxt.failed = 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== hdl/size_string_parser_core.sv =====
// Size string parser: one character item per cycle unless stalled, one result item per string.
// A zero-byte item is held in the input register and its result is captured in the result register.
// Throughput: one character per cycle, set by the combinational parse step between
// the input register and the result register; a stalled result only holds back a
// following zero byte, other characters keep flowing.
// Reset: arst_n clears the parse state and both valid flags; payloads are not reset.
module size_string_parser_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           char_valid,
	output logic                           char_stall,
	input  logic [ssp_pkg::CHAR_W-1:0]     character,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [ssp_pkg::VALUE_W-1:0]    size_bytes,
	output logic                           parse_error
);

	// Input register
	logic                          valid_s1;
	logic [ssp_pkg::CHAR_W-1:0]    char_s1;

	// Parse state carried across characters of one string
	ssp_pkg::parse_state_t         state_q;
	ssp_pkg::parse_state_t         state_nxt;

	// Result register
	logic                          out_valid_s2;
	logic [ssp_pkg::VALUE_W-1:0]   size_s2;
	logic                          err_s2;

	logic [ssp_pkg::VALUE_W-1:0]   step_size;
	logic                          step_err;
	logic                          is_term;
	logic                          advance;

	assign is_term = (char_s1 == ssp_pkg::CH_NUL);

	// Advance the held character unless it is a terminator blocked by a stalled result
	assign advance    = valid_s1 && (!is_term || !out_valid_s2 || !result_stall);
	assign char_stall = valid_s1 && !advance;

	ssp_step u_step (
		.cur         (state_q),
		.character   (char_s1),
		.nxt         (state_nxt),
		.size_bytes  (step_size),
		.parse_error (step_err)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			state_q      <= ssp_pkg::STATE_RESET;
			out_valid_s2 <= 1'b0;
		end else begin
			// Load the input register whenever it is not holding a blocked item
			if (!char_stall) begin
				valid_s1 <= char_valid;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
			// A terminator fills the result register; an accepted result drops it
			if (advance && is_term) begin
				out_valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			char_s1 <= character;
		end
		if (advance && is_term) begin
			size_s2 <= step_size;
			err_s2  <= step_err;
		end
	end

	assign result_valid = out_valid_s2;
	assign size_bytes   = size_s2;
	assign parse_error  = err_s2;

	// An error result always carries a zero count
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && err_s2 |-> size_s2 == '0)
		else $error("error result with non-zero size");

	// Input side only stalls on a terminator behind a full, stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> valid_s1 && is_term && out_valid_s2 && result_stall)
		else $error("input stalled without a blocked terminator");

	// Each processed terminator returns the parse state to its reset value
	a_term_reset: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_term |=> state_q == ssp_pkg::STATE_RESET && out_valid_s2)
		else $error("parse state not cleared after terminator");

	// A result blocked downstream is never overwritten or lost
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && result_stall |=> out_valid_s2 && $stable(size_s2) && $stable(err_s2))
		else $error("stalled result changed");

endmodule
